### hdl/prq_pkg.sv
// Package for the priority run queue manager.
// Field widths, operation and status codes, controller/datapath interface structs.
// No dependencies.
package prq_pkg;

  localparam int MODE_W       = 1;
  localparam int SLOT_FIELD_W = 6;
  localparam int PRIO_FIELD_W = 7;
  localparam int STATUS_W     = 2;
  localparam int MAP_W        = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_QUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

  typedef struct packed {
    logic clr;
    logic issue;
    logic exec;
    logic link;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/prq_ram.sv
// Generic single write port, single read port RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/prq_ctrl.sv
// Sequencing state machine of the run queue manager.
// Depends on prq_pkg for the command and status structs.
module prq_ctrl import prq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_LINK = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.issue = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_LINK;
      end
      ST_LINK: begin
        cmd_o.link     = 1'b1;
        cmd_o.out_load = sts_i.out_free;
        state_d        = sts_i.out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/prq_datapath.sv
// Datapath of the run queue manager: link RAMs, queued-flag RAM, occupancy
// map and result register. Depends on prq_pkg and prq_ram.
module prq_datapath import prq_pkg::*; #(
  parameter int PROCESS_SLOTS = 64,
  parameter int QUEUE_COUNT   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic [MODE_W-1:0]      in_mode_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int NODES      = PROCESS_SLOTS + QUEUE_COUNT;
  localparam int NW         = $clog2(NODES);
  localparam int SW         = $clog2(PROCESS_SLOTS);
  localparam int QW         = $clog2(QUEUE_COUNT);
  localparam int SLOT_CODES = 1 << SLOT_FIELD_W;
  localparam int QUEUE_CODES = 1 << (PRIO_FIELD_W - 2);

  function automatic logic [SLOT_CODES-1:0][SW-1:0] slot_wrap_table();
    logic [SLOT_CODES-1:0][SW-1:0] t;
    for (int i = 0; i < SLOT_CODES; i++) begin
      t[i] = SW'(i % PROCESS_SLOTS);
    end
    return t;
  endfunction

  function automatic logic [QUEUE_CODES-1:0][QW-1:0] queue_wrap_table();
    logic [QUEUE_CODES-1:0][QW-1:0] t;
    for (int i = 0; i < QUEUE_CODES; i++) begin
      t[i] = QW'(i % QUEUE_COUNT);
    end
    return t;
  endfunction

  localparam logic [SLOT_CODES-1:0][SW-1:0]  SLOT_WRAP  = slot_wrap_table();
  localparam logic [QUEUE_CODES-1:0][QW-1:0] QUEUE_WRAP = queue_wrap_table();

  logic [SLOT_FIELD_W-1:0] slot_field;
  logic [PRIO_FIELD_W-1:0] prio_field;
  logic [SW-1:0]           slot_in;
  logic [QW-1:0]           queue_in;
  logic [NW-1:0]           head_in;

  logic [MODE_W-1:0]   mode_q;
  logic [SW-1:0]       slot_q;
  logic [QW-1:0]       queue_q;
  logic [NW-1:0]       head_q;
  logic [NW-1:0]       slot_node;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                ins_q, ins_d, rem_q, rem_d;
  logic [NW-1:0]       lnk_a_q, lnk_b_q;
  logic [NW-1:0]       clr_cnt_q;
  logic [QUEUE_COUNT-1:0] map_q, map_d;
  logic                out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [NW-1:0]       head_fwd;

  logic          fwd_we, bwd_we, qd_we;
  logic [NW-1:0] fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
  logic [NW-1:0] bwd_waddr, bwd_wdata, bwd_raddr, bwd_rdata;
  logic [SW-1:0] qd_waddr, qd_raddr;
  logic          qd_wdata, qd_rdata;

  assign slot_field = in_data_i[SLOT_FIELD_W-1:0];
  assign prio_field = in_data_i[SLOT_FIELD_W +: PRIO_FIELD_W];
  assign slot_in    = SLOT_WRAP[slot_field];
  assign queue_in   = QUEUE_WRAP[prio_field[PRIO_FIELD_W-1:2]];
  assign head_in    = NW'(PROCESS_SLOTS) + NW'(queue_in);
  assign slot_node  = NW'(slot_q);

  // decision on the link and flag data read at accept
  always_comb begin
    ins_d    = 1'b0;
    rem_d    = 1'b0;
    status_d = STATUS_DONE;
    if (mode_q == MODE_INSERT) begin
      if (qd_rdata) begin
        status_d = STATUS_QUEUED;
      end else begin
        ins_d = 1'b1;
      end
    end else if (!map_q[queue_q]) begin
      status_d = STATUS_EMPTY;
    end else begin
      rem_d = qd_rdata;
    end
  end

  always_comb begin
    fwd_raddr = cmd_i.issue ? NW'(slot_in) : head_q;
    bwd_raddr = (in_mode_i == MODE_INSERT) ? head_in : NW'(slot_in);
    qd_raddr  = slot_in;
    fwd_we    = 1'b0;
    fwd_waddr = '0;
    fwd_wdata = '0;
    bwd_we    = 1'b0;
    bwd_waddr = '0;
    bwd_wdata = '0;
    qd_we     = 1'b0;
    qd_waddr  = slot_q;
    qd_wdata  = 1'b0;
    priority if (cmd_i.clr) begin
      fwd_we    = 1'b1;
      fwd_waddr = clr_cnt_q;
      fwd_wdata = clr_cnt_q;
      bwd_we    = 1'b1;
      bwd_waddr = clr_cnt_q;
      bwd_wdata = clr_cnt_q;
      qd_we     = clr_cnt_q < NW'(PROCESS_SLOTS);
      qd_waddr  = clr_cnt_q[SW-1:0];
    end else if (cmd_i.exec && ins_d) begin
      fwd_we    = 1'b1;
      fwd_waddr = slot_node;
      fwd_wdata = head_q;
      bwd_we    = 1'b1;
      bwd_waddr = slot_node;
      bwd_wdata = bwd_rdata;
      qd_we     = 1'b1;
      qd_wdata  = 1'b1;
    end else if (cmd_i.exec && rem_d) begin
      fwd_we    = 1'b1;
      fwd_waddr = bwd_rdata;
      fwd_wdata = fwd_rdata;
      bwd_we    = 1'b1;
      bwd_waddr = fwd_rdata;
      bwd_wdata = bwd_rdata;
      qd_we     = 1'b1;
    end else if (cmd_i.link && ins_q) begin
      fwd_we    = 1'b1;
      fwd_waddr = lnk_a_q;
      fwd_wdata = slot_node;
      bwd_we    = 1'b1;
      bwd_waddr = head_q;
      bwd_wdata = slot_node;
    end
  end

  // header forward link after the unlink; the RAM read misses a write at prev == head
  assign head_fwd = (lnk_b_q == head_q) ? lnk_a_q : fwd_rdata;

  always_comb begin
    map_d = map_q;
    if (cmd_i.link) begin
      if (ins_q) begin
        map_d[queue_q] = 1'b1;
      end else if (rem_q && head_fwd == head_q) begin
        map_d[queue_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      mode_q  <= in_mode_i;
      slot_q  <= slot_in;
      queue_q <= queue_in;
      head_q  <= head_in;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      lnk_a_q  <= (mode_q == MODE_INSERT) ? bwd_rdata : fwd_rdata;
      lnk_b_q  <= bwd_rdata;
    end
    if (cmd_i.out_load) begin
      out_data_q <= OUT_TDATA_W'({32'(map_d), status_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      ins_q       <= 1'b0;
      rem_q       <= 1'b0;
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.exec) begin
        ins_q <= ins_d;
        rem_q <= rem_d;
      end
      map_q <= map_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clear_last = clr_cnt_q == NW'(NODES - 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;

  prq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .raddr_i (fwd_raddr),
    .rdata_o (fwd_rdata)
  );

  prq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (bwd_we),
    .waddr_i (bwd_waddr),
    .wdata_i (bwd_wdata),
    .raddr_i (bwd_raddr),
    .rdata_o (bwd_rdata)
  );

  prq_ram #(.WIDTH(1), .DEPTH(PROCESS_SLOTS)) u_queued_ram (
    .clk_i   (clk_i),
    .we_i    (qd_we),
    .waddr_i (qd_waddr),
    .wdata_i (qd_wdata),
    .raddr_i (qd_raddr),
    .rdata_o (qd_rdata)
  );

endmodule

### hdl/priority_run_queue_manager.sv
// Priority run queue manager: linked run queues with an occupancy map.
// Requests are handled one at a time, paced by the read-then-write sequence on the shared link
// RAMs (one write port each); a stalled result output also holds off the next request.
// Reset: a sweep over all PROCESS_SLOTS + QUEUE_COUNT link nodes initializes the queue headers
// and clears the queued flags; no request is accepted until it ends.
// Depends on prq_pkg, prq_ctrl, prq_datapath, prq_ram.
module priority_run_queue_manager import prq_pkg::*; #(
  parameter int PROCESS_SLOTS = 64,
  parameter int QUEUE_COUNT   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // process_slot[5:0], priority_req[12:6]
  input  logic [MODE_W-1:0]      s_axis_tuser,  // mode[0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status[1:0], nonempty_map[33:2]
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  prq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prq_datapath #(
    .PROCESS_SLOTS (PROCESS_SLOTS),
    .QUEUE_COUNT   (QUEUE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### verif/tb_priority_run_queue_manager.sv
// Testbench for priority_run_queue_manager: directed table, then random insert/remove traffic.
// Results are checked against a linked-list run queue predictor kept in this file.
// Depends on prq_pkg and the priority_run_queue_manager RTL.
module tb_priority_run_queue_manager;
  import prq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 64;
  localparam int QUEUES       = 32;
  localparam int NODES        = SLOTS + QUEUES;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_AT     = 900;
  localparam int STALL_CYCLES = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MAP_W-1:0]    map;
  } rq_result_t;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PRIO_FIELD_W-1:0] prio;
    bit                      typed;
    logic [STATUS_W-1:0]     status;
    logic [MAP_W-1:0]        map;
  } directed_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = MODE_INSERT;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // predictor state: nodes 0..SLOTS-1 are slots, the rest queue headers
  logic [6:0]              fwd_link [NODES];
  logic [6:0]              bwd_link [NODES];
  logic                    slot_queued [SLOTS];
  logic [MAP_W-1:0]        occ_map;
  logic [PRIO_FIELD_W-1:0] slot_prio [SLOTS];

  rq_result_t expected_results [$];
  int         error_count = 0;
  int         accepted_count = 0;
  int         result_count = 0;

  directed_row_t directed_rows [25] = '{
    '{MODE_REMOVE, 6'd0,  7'd0,   1'b1, STATUS_EMPTY,  32'h0000_0000},
    '{MODE_REMOVE, 6'd63, 7'd127, 1'b1, STATUS_EMPTY,  32'h0000_0000},
    '{MODE_INSERT, 6'd0,  7'd0,   1'b1, STATUS_DONE,   32'h0000_0001},
    '{MODE_INSERT, 6'd0,  7'd0,   1'b1, STATUS_QUEUED, 32'h0000_0001},
    '{MODE_INSERT, 6'd0,  7'd127, 1'b1, STATUS_QUEUED, 32'h0000_0001},
    '{MODE_INSERT, 6'd63, 7'd127, 1'b1, STATUS_DONE,   32'h8000_0001},
    '{MODE_INSERT, 6'd42, 7'd127, 1'b1, STATUS_DONE,   32'h8000_0001},
    '{MODE_INSERT, 6'd21, 7'd126, 1'b1, STATUS_DONE,   32'h8000_0001},
    '{MODE_REMOVE, 6'd42, 7'd124, 1'b1, STATUS_DONE,   32'h8000_0001},
    '{MODE_REMOVE, 6'd5,  7'd0,   1'b1, STATUS_DONE,   32'h8000_0001},
    '{MODE_INSERT, 6'd10, 7'd4,   1'b1, STATUS_DONE,   32'h8000_0003},
    '{MODE_REMOVE, 6'd10, 7'd0,   1'b1, STATUS_DONE,   32'h8000_0003},
    '{MODE_REMOVE, 6'd0,  7'd3,   1'b1, STATUS_DONE,   32'h8000_0002},
    '{MODE_REMOVE, 6'd10, 7'd4,   1'b1, STATUS_DONE,   32'h8000_0002},
    '{MODE_INSERT, 6'd10, 7'd5,   1'b1, STATUS_DONE,   32'h8000_0002},
    '{MODE_REMOVE, 6'd10, 7'd6,   1'b1, STATUS_DONE,   32'h8000_0000},
    '{MODE_REMOVE, 6'd10, 7'd4,   1'b1, STATUS_EMPTY,  32'h8000_0000},
    '{MODE_REMOVE, 6'd63, 7'd127, 1'b1, STATUS_DONE,   32'h8000_0000},
    '{MODE_REMOVE, 6'd21, 7'd125, 1'b1, STATUS_DONE,   32'h0000_0000},
    '{MODE_REMOVE, 6'd21, 7'd127, 1'b1, STATUS_EMPTY,  32'h0000_0000},
    '{MODE_INSERT, 6'd1,  7'd64,  1'b0, STATUS_DONE,   32'h0},
    '{MODE_INSERT, 6'd2,  7'd65,  1'b0, STATUS_DONE,   32'h0},
    '{MODE_INSERT, 6'd3,  7'd66,  1'b0, STATUS_DONE,   32'h0},
    '{MODE_REMOVE, 6'd2,  7'd67,  1'b0, STATUS_DONE,   32'h0},
    '{MODE_REMOVE, 6'd1,  7'd8,   1'b0, STATUS_DONE,   32'h0}
  };

  priority_run_queue_manager uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_queues();
    for (int i = 0; i < NODES; i++) begin
      fwd_link[i] = 7'(i);
      bwd_link[i] = 7'(i);
    end
    for (int i = 0; i < SLOTS; i++) begin
      slot_queued[i] = 1'b0;
      slot_prio[i]   = '0;
    end
    occ_map = '0;
  endfunction

  function automatic rq_result_t apply_request(logic [MODE_W-1:0] mode,
                                               logic [SLOT_FIELD_W-1:0] slot,
                                               logic [PRIO_FIELD_W-1:0] prio);
    rq_result_t res;
    logic [4:0] q;
    logic [6:0] head;
    logic [6:0] last;
    logic [6:0] nxt;
    logic [6:0] prv;
    q = prio[6:2];
    head = 7'(SLOTS) + 7'(q);
    res.status = STATUS_DONE;
    if (mode == MODE_INSERT) begin
      if (slot_queued[slot]) begin
        res.status = STATUS_QUEUED;
      end else begin
        last = bwd_link[head];
        occ_map[q] = 1'b1;
        fwd_link[slot] = head;
        bwd_link[slot] = last;
        bwd_link[head] = 7'(slot);
        fwd_link[last] = 7'(slot);
        slot_queued[slot] = 1'b1;
      end
    end else if (!occ_map[q]) begin
      res.status = STATUS_EMPTY;
    end else if (slot_queued[slot]) begin
      nxt = fwd_link[slot];
      prv = bwd_link[slot];
      bwd_link[nxt] = prv;
      fwd_link[prv] = nxt;
      slot_queued[slot] = 1'b0;
      if (fwd_link[head] == head) begin
        occ_map[q] = 1'b0;
      end
    end
    res.map = occ_map;
    return res;
  endfunction

  // first slot at or after a random start whose queued flag matches, -1 if none
  function automatic int find_slot(logic want_queued);
    int start;
    int s;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      s = (start + i) % SLOTS;
      if (slot_queued[s] == want_queued) begin
        return s;
      end
    end
    return -1;
  endfunction

  function automatic void count_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] error: %s", $realtime, msg);
    end
  endfunction

  task automatic issue_request(logic [MODE_W-1:0] mode, logic [SLOT_FIELD_W-1:0] slot,
                               logic [PRIO_FIELD_W-1:0] prio, bit typed, rq_result_t typed_res,
                               bit quiet);
    int gap;
    rq_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, prio, slot};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = apply_request(mode, slot, prio);
    if (mode == MODE_INSERT && res.status == STATUS_DONE) begin
      slot_prio[slot] = prio;
    end
    expected_results.push_back(typed ? typed_res : res);
    accepted_count++;
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // result side: random hold-offs, one long stall, quiet bands
  initial begin
    int gap;
    rq_result_t want;
    logic [STATUS_W-1:0] got_status;
    logic [MAP_W-1:0] got_map;
    forever begin
      if (result_count == STALL_AT) begin
        gap = STALL_CYCLES;
      end else if ((result_count / 150) % 4 == 2) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 3);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got_status = m_axis_tdata[1:0];
      got_map = m_axis_tdata[33:2];
      result_count++;
      if (expected_results.size() == 0) begin
        count_error($sformatf("result with no request pending: status %0d map %h",
                              got_status, got_map));
      end else begin
        want = expected_results.pop_front();
        if (got_status !== want.status) begin
          count_error($sformatf("result %0d status: expected %0d, got %0d",
                                result_count, want.status, got_status));
        end
        if (got_map !== want.map) begin
          count_error($sformatf("result %0d map: expected %h, got %h",
                                result_count, want.map, got_map));
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rq_result_t typed_res;
    logic [MODE_W-1:0] mode;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PRIO_FIELD_W-1:0] prio;
    int pick;
    int found;
    int hot_base;
    bit quiet;
    clear_queues();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].status;
      typed_res.map    = directed_rows[i].map;
      issue_request(directed_rows[i].mode, directed_rows[i].slot, directed_rows[i].prio,
                    directed_rows[i].typed, typed_res, 1'b0);
    end
    wait_for_drain();

    hot_base = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        wait_for_drain();
      end
      if (n % 200 == 0) begin
        hot_base = $urandom_range(0, QUEUES - 4);
      end
      quiet = ((n / 150) % 4 == 1);
      pick = $urandom_range(0, 99);
      mode = MODE_INSERT;
      slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
      prio = PRIO_FIELD_W'($urandom_range(0, 127));
      if (pick < 44) begin
        found = find_slot(1'b0);
        if (found >= 0) begin
          slot = SLOT_FIELD_W'(found);
        end
        if ($urandom_range(0, 9) < 6) begin
          prio = {5'(hot_base + $urandom_range(0, 3)), 2'($urandom_range(0, 3))};
        end
      end else if (pick < 86) begin
        mode = MODE_REMOVE;
        found = find_slot(1'b1);
        if (found >= 0) begin
          slot = SLOT_FIELD_W'(found);
          prio = {slot_prio[found][6:2], 2'($urandom_range(0, 3))};
        end
      end else begin
        mode = MODE_WIDTH_PICK(pick);
      end
      issue_request(mode, slot, prio, 1'b0, typed_res, quiet);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // noise items: insert or remove with fully random slot and priority
  function automatic logic [MODE_W-1:0] MODE_WIDTH_PICK(int pick);
    return (pick % 2 == 0) ? MODE_INSERT : MODE_REMOVE;
  endfunction

endmodule
